[hw/rtl/kwm_pkg.sv]
`timescale 1ns / 1ps

package kwm_pkg;

  localparam int ValueW         = 31;
  localparam int ListW          = 6;
  localparam int CountW         = 7;
  localparam int ActionW        = 2;
  localparam int DefaultMaxLists = 64;

  typedef enum logic [ActionW-1:0] {
    ACT_LOAD    = 2'd0,
    ACT_BUILD   = 2'd1,
    ACT_REPLACE = 2'd2,
    ACT_NOP     = 2'd3
  } action_e;

  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [ListW-1:0]   list_id;
    logic [ValueW-1:0]  value;
  } item_t;

  typedef struct packed {
    logic [ValueW-1:0] top_value;
    logic [ListW-1:0]  top_list;
    logic              done_res;
  } result_t;

  // One heap slot: the head value and the list it came from.
  typedef struct packed {
    logic [ListW-1:0]  list;
    logic [ValueW-1:0] value;
  } entry_t;

endpackage

[hw/rtl/kwm_heap_ram.sv]
`timescale 1ns / 1ps

module kwm_heap_ram #(
  parameter int Depth = kwm_pkg::DefaultMaxLists,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AddrW-1:0]      waddr_i,
  input  kwm_pkg::entry_t       wdata_i,
  input  logic                  re_i,
  input  logic [AddrW-1:0]      raddr_i,
  output kwm_pkg::entry_t       rdata_o
);

  kwm_pkg::entry_t mem_q [Depth];
  kwm_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/kway_merge_4ary_max_heap.sv]
`timescale 1ns / 1ps

// Port group   Direction  Ports                      Beat taken when
// item         in         start, busy, item_i        start high and busy low
// result       out        res_valid_o, res_o         res_valid_o high (one cycle)
// list_count   in         cfg_we_i, cfg_wdata_i      cfg_we_i high
//
// A load, an unused action or a small build goes from idle straight to the report state.
// A sift-down level steps through S_LEVEL, S_SCAN and S_DEC and reads its children one at a time
// through the single memory read port; S_DEC writes the larger of the key and the best child.
// Build repeats the sift-down for every parent, last one first.
// Reset leaves the heap memory undefined; only the control state and list_count clear.
// A result is shown for one cycle and cannot be held off; busy drops as it shows.
module kway_merge_4ary_max_heap #(
  parameter int MAX_LISTS = kwm_pkg::DefaultMaxLists
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  kwm_pkg::item_t                item_i,
  output logic                          res_valid_o,
  output kwm_pkg::result_t              res_o,
  input  logic                          cfg_we_i,
  input  logic [kwm_pkg::CountW-1:0]    cfg_wdata_i
);

  localparam int AW = $clog2(MAX_LISTS);
  localparam int SW = AW + 1;
  localparam int FW = AW + 3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_KEY,
    S_LEVEL,
    S_SCAN,
    S_DEC,
    S_REPORT
  } state_e;

  state_e                       state_q;
  logic [kwm_pkg::CountW-1:0]   list_count_q;
  logic                         build_q;
  logic [AW-1:0]                bld_q;
  logic [AW-1:0]                pos_q;
  kwm_pkg::entry_t              key_q;
  kwm_pkg::entry_t              best_q;
  logic [AW-1:0]                best_idx_q;
  logic [FW-1:0]                first_q;
  logic [2:0]                   nch_q;
  logic [2:0]                   iss_q;
  logic [2:0]                   got_q;
  kwm_pkg::entry_t              top_q;
  logic                         res_valid_q;
  kwm_pkg::result_t             res_q;

  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  kwm_pkg::entry_t              mem_wdata;
  logic                         mem_re;
  logic [AW-1:0]                mem_raddr;
  kwm_pkg::entry_t              mem_rdata;

  logic [SW-1:0]                size_w;
  logic [FW-1:0]                size_f;
  logic [FW-1:0]                first_w;
  logic [FW-1:0]                rem_w;
  logic [2:0]                   nch_w;
  logic                         leaf_w;
  logic                         accept_w;
  logic                         load_ok_w;
  logic                         build_ok_w;
  logic                         sink_end_w;
  logic                         more_build_w;
  logic                         key_wins_w;
  logic                         cand_wins_w;

  assign accept_w = start && !busy;

  assign size_w = ({25'd0, list_count_q} > 32'(MAX_LISTS)) ? SW'(MAX_LISTS)
                                                             : SW'(list_count_q);
  assign size_f  = FW'(size_w);
  assign first_w = {1'b0, pos_q, 2'b01};
  assign leaf_w  = first_w >= size_f;
  assign rem_w   = size_f - first_w;
  assign nch_w   = (rem_w > FW'(4)) ? 3'd4 : rem_w[2:0];

  assign load_ok_w   = 32'(item_i.list_id) < 32'(MAX_LISTS);
  assign build_ok_w  = size_w >= SW'(2);
  assign key_wins_w  = key_q.value >= best_q.value;
  assign cand_wins_w = (got_q == 3'd0) || (mem_rdata.value > best_q.value);

  // A sift-down ends when the key lands at its slot.
  assign sink_end_w   = ((state_q == S_LEVEL) && leaf_w) ||
                        ((state_q == S_DEC) && key_wins_w);
  assign more_build_w = build_q && (bld_q != '0);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos_q;
    mem_wdata = key_q;
    mem_re    = 1'b0;
    mem_raddr = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept_w && item_i.action == kwm_pkg::ACT_LOAD && load_ok_w) begin
          mem_we          = 1'b1;
          mem_waddr       = AW'(item_i.list_id);
          mem_wdata.list  = item_i.list_id;
          mem_wdata.value = item_i.value;
        end
        if (accept_w && item_i.action == kwm_pkg::ACT_BUILD && build_ok_w) begin
          mem_re    = 1'b1;
          mem_raddr = AW'((size_w - SW'(2)) >> 2);
        end
      end
      S_LEVEL: begin
        if (!leaf_w) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(first_w);
        end
      end
      S_SCAN: begin
        if (iss_q < nch_q) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(first_q + FW'(iss_q));
        end
      end
      S_DEC: begin
        mem_we = 1'b1;
        if (!key_wins_w) begin
          mem_wdata = best_q;
        end
      end
      default: begin
      end
    endcase
    if (sink_end_w) begin
      mem_we = 1'b1;
      if (more_build_w) begin
        // Next parent to the left; it lies below the slot being written.
        mem_re    = 1'b1;
        mem_raddr = bld_q - AW'(1);
      end
    end
  end

  kwm_heap_ram #(
    .Depth (MAX_LISTS),
    .AddrW (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      list_count_q <= '0;
      build_q      <= 1'b0;
      res_valid_q  <= 1'b0;
      iss_q        <= '0;
      got_q        <= '0;
      nch_q        <= '0;
    end else begin
      res_valid_q <= 1'b0;
      if (cfg_we_i) begin
        list_count_q <= cfg_wdata_i;
      end
      // Slot 0 is mirrored so the top can be reported without a read.
      if (mem_we && mem_waddr == '0) begin
        top_q <= mem_wdata;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept_w) begin
            build_q <= 1'b0;
            state_q <= S_REPORT;
            if (item_i.action == kwm_pkg::ACT_BUILD && build_ok_w) begin
              build_q <= 1'b1;
              bld_q   <= AW'((size_w - SW'(2)) >> 2);
              pos_q   <= AW'((size_w - SW'(2)) >> 2);
              state_q <= S_KEY;
            end else if (item_i.action == kwm_pkg::ACT_REPLACE) begin
              pos_q       <= '0;
              key_q.list  <= top_q.list;
              key_q.value <= item_i.value;
              state_q     <= S_LEVEL;
            end
          end
        end
        S_KEY: begin
          key_q   <= mem_rdata;
          state_q <= S_LEVEL;
        end
        S_LEVEL: begin
          if (!leaf_w) begin
            first_q <= first_w;
            nch_q   <= nch_w;
            iss_q   <= 3'd1;
            got_q   <= 3'd0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (iss_q < nch_q) begin
            iss_q <= iss_q + 3'd1;
          end
          if (cand_wins_w) begin
            best_q     <= mem_rdata;
            best_idx_q <= AW'(first_q + FW'(got_q));
          end
          got_q <= got_q + 3'd1;
          if (got_q == nch_q - 3'd1) begin
            state_q <= S_DEC;
          end
        end
        S_DEC: begin
          if (!key_wins_w) begin
            pos_q   <= best_idx_q;
            state_q <= S_LEVEL;
          end
        end
        S_REPORT: begin
          res_valid_q     <= 1'b1;
          res_q.top_value <= top_q.value;
          res_q.top_list  <= top_q.list;
          res_q.done_res  <= (top_q.value == '0);
          state_q         <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      if (sink_end_w) begin
        if (more_build_w) begin
          bld_q   <= bld_q - AW'(1);
          pos_q   <= bld_q - AW'(1);
          state_q <= S_KEY;
        end else begin
          state_q <= S_REPORT;
        end
      end
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_no_back_to_back_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |=> !res_valid_q)
    else $error("result strobe held for two cycles");

  a_accept_goes_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_w |=> busy)
    else $error("accepted beat did not make the engine busy");

  a_no_rw_collision : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("read and write hit the same heap slot in one cycle");

  a_scan_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (got_q < nch_q && nch_q <= 3'd4))
    else $error("child scan ran past the children of the node");

  a_done_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.done_res == (res_o.top_value == '0)))
    else $error("done flag disagrees with the top value");

endmodule
